@@ rtl/core/cod_pkg.sv @@
// ----------------------------------------------------------------------------
// cod_pkg
// Shared types and constants of the clock offset and drift estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package cod_pkg;

    localparam int TIME_WIDTH_DEF  = 64;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int GAIN_W   = 17;
    localparam int LTIME_W  = 63;
    localparam int RTIME_W  = 64;
    localparam int DRIFT_W  = 32;
    localparam int COUNT_W  = 32;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;

    localparam int MUL_A_W  = 64;
    localparam int MUL_H_W  = 32;
    localparam int MUL_B_W  = 20;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int QUOT_W   = 49;

    localparam logic [MUL_B_W-1:0] MEGA        = 20'd1000000;
    localparam logic [QUOT_W-1:0]  SAMPLE_CLAMP = {1'b1, {(QUOT_W-1){1'b0}}};

    localparam logic [1:0] REG_GOOD_GAIN   = 2'd0;
    localparam logic [1:0] REG_NORMAL_GAIN = 2'd1;
    localparam logic [1:0] REG_DRIFT_GAIN  = 2'd2;
    localparam logic [1:0] REG_INTERVAL    = 2'd3;

    localparam logic [GAIN_W-1:0]  GOOD_GAIN_RST   = 17'd32768;
    localparam logic [GAIN_W-1:0]  NORMAL_GAIN_RST = 17'd6554;
    localparam logic [GAIN_W-1:0]  DRIFT_GAIN_RST  = 17'd13107;
    localparam logic [LTIME_W-1:0] INTERVAL_RST    = 63'd1000000000;

    typedef struct packed {
        logic [GAIN_W-1:0]  good_gain;
        logic [GAIN_W-1:0]  normal_gain;
        logic [GAIN_W-1:0]  drift_gain;
        logic [LTIME_W-1:0] interval;
    } cod_cfg_t;

    typedef struct packed {
        logic en;
        logic hi;
    } cod_mul_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/clock_offset_drift_estimator.sv @@
// ----------------------------------------------------------------------------
// clock_offset_drift_estimator
// Filters timing exchanges into a smoothed clock offset, minimum round trip
// and drift in ppm, using one shared multiplier and a bit-serial divider.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  send, remote, receive time
//  result    out        result_valid / result_stall  offset, round trips, drift
//  config    in         APB (psel, penable, pready)  gains, drift interval
//
// A rejected sample ends at the round trip check, the first accepted one
// seeds the offset, and a later one updates it and, past the drift interval,
// the drift via the 49-step restoring divider unless the drift sample clamps.
// The finished result sits in an output register, so the next sample is
// taken while the result is stalled; a further result waits in the last step.
// Reset clears all estimator state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_offset_drift_estimator
    import cod_pkg::*;
#(
    parameter int TIME_WIDTH      = TIME_WIDTH_DEF,
    parameter int DRIFT_FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic      [DATA_W-1:0]         prdata,
    output logic                           pready,

    input  wire logic                      sample_valid,
    output logic                           sample_stall,
    input  wire logic        [LTIME_W-1:0] local_send_time,
    input  wire logic signed [RTIME_W-1:0] remote_receive_time,
    input  wire logic        [LTIME_W-1:0] local_receive_time,

    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic                           accepted,
    output logic signed      [RTIME_W-1:0] offset_estimate,
    output logic             [LTIME_W-1:0] min_round_trip,
    output logic             [LTIME_W-1:0] last_round_trip,
    output logic signed      [DRIFT_W-1:0] drift_ppm,
    output logic                           drift_updated,
    output logic                           have_estimate,
    output logic             [COUNT_W-1:0] samples_taken
);

    localparam logic [LTIME_W-1:0] LOCAL_MASK = {LTIME_W{1'b1}} >> (RTIME_W - TIME_WIDTH);
    localparam int REM_SHIFT = RTIME_W - TIME_WIDTH;
    localparam int NUM_W     = PROD_W + DRIFT_FRAC_BITS;
    localparam int CNT_W     = $clog2(QUOT_W);
    localparam int OFS_W     = RTIME_W + 6;
    localparam int SUM_W     = 52;
    localparam int TNEW_W    = 50;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RTT  = 5'd1;
    localparam logic [4:0] S_MID  = 5'd2;
    localparam logic [4:0] S_INST = 5'd3;
    localparam logic [4:0] S_DIFF = 5'd4;
    localparam logic [4:0] S_OMH  = 5'd5;
    localparam logic [4:0] S_OML  = 5'd6;
    localparam logic [4:0] S_OFS  = 5'd7;
    localparam logic [4:0] S_DMH  = 5'd8;
    localparam logic [4:0] S_DML  = 5'd9;
    localparam logic [4:0] S_DCHK = 5'd10;
    localparam logic [4:0] S_DIV  = 5'd11;
    localparam logic [4:0] S_SCLP = 5'd12;
    localparam logic [4:0] S_TMH  = 5'd13;
    localparam logic [4:0] S_TML  = 5'd14;
    localparam logic [4:0] S_TNEW = 5'd15;
    localparam logic [4:0] S_OLH  = 5'd16;
    localparam logic [4:0] S_OLL  = 5'd17;
    localparam logic [4:0] S_DSUM = 5'd18;
    localparam logic [4:0] S_FIN  = 5'd19;
    localparam logic [4:0] S_DONE = 5'd20;

    localparam logic [RTIME_W-1:0] OFS_MAX = {1'b0, {(RTIME_W-1){1'b1}}};
    localparam logic [RTIME_W-1:0] OFS_MIN = {1'b1, {(RTIME_W-1){1'b0}}};
    localparam logic [DRIFT_W-1:0] DRIFT_MAX = {1'b0, {(DRIFT_W-1){1'b1}}};
    localparam logic [DRIFT_W-1:0] DRIFT_MIN = {1'b1, {(DRIFT_W-1){1'b0}}};

    cod_cfg_t     cfg;
    cod_mul_ctl_t mul_ctl;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;

    logic [4:0]         state_reg,    state_next;
    logic [LTIME_W-1:0] send_reg,     send_next;
    logic [LTIME_W-1:0] recv_reg,     recv_next;
    logic [RTIME_W-1:0] remote_reg,   remote_next;
    logic [LTIME_W-1:0] rtt_reg,      rtt_next;
    logic [LTIME_W-1:0] sub_reg,      sub_next;
    logic [RTIME_W-1:0] inst_reg,     inst_next;
    logic               neg_reg,      neg_next;
    logic [MUL_A_W-1:0] mag_reg,      mag_next;
    logic [GAIN_W-1:0]  gain_reg,     gain_next;
    logic [LTIME_W-1:0] dt_reg,       dt_next;
    logic               dt_pos_reg,   dt_pos_next;
    logic [LTIME_W-1:0] rem_reg,      rem_next;
    logic [QUOT_W-1:0]  num_reg,      num_next;
    logic [QUOT_W-1:0]  q_reg,        q_next;
    logic [CNT_W-1:0]   cnt_reg,      cnt_next;
    logic [TNEW_W-1:0]  tnew_reg,     tnew_next;

    logic               acc_flag_reg, acc_flag_next;
    logic               upd_flag_reg, upd_flag_next;
    logic               valid_reg,    valid_next;
    logic [RTIME_W-1:0] offset_reg,   offset_next;
    logic [LTIME_W-1:0] min_rtt_reg,  min_rtt_next;
    logic [LTIME_W-1:0] last_rtt_reg, last_rtt_next;
    logic [LTIME_W-1:0] prev_time_reg, prev_time_next;
    logic [DRIFT_W-1:0] drift_reg,    drift_next;
    logic [COUNT_W-1:0] count_reg,    count_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg;
    logic [RTIME_W-1:0] out_offset_reg;
    logic [LTIME_W-1:0] out_min_reg;
    logic [LTIME_W-1:0] out_last_reg;
    logic [DRIFT_W-1:0] out_drift_reg;
    logic               out_upd_reg;
    logic               out_have_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               take;
    logic               load;
    logic [RTIME_W-1:0] remote_shl;
    logic [RTIME_W-1:0] remote_ext;
    logic [RTIME_W-1:0] rtt_wide;
    logic [RTIME_W:0]   inst_wide;
    logic [RTIME_W:0]   diff_ab;
    logic [RTIME_W:0]   diff_ba;
    logic [RTIME_W-1:0] dt_wide;
    logic [PROD_W-MUL_B_W+3:0] ofs_p;
    logic [OFS_W-1:0]   ofs_sum;
    logic [NUM_W-1:0]   num_full;
    logic [LTIME_W-1:0] top_ext;
    logic [RTIME_W-1:0] rem_shift;
    logic               rem_ge;
    logic signed [GAIN_W:0] old_w;
    logic               old_w_neg;
    logic [GAIN_W-1:0]  old_w_mag;
    logic [DRIFT_W-1:0] drift_mag;
    logic [SUM_W-1:0]   told_s;
    logic [SUM_W-1:0]   drift_sum;

    cod_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cod_mul u_mul
    (
        .clk  (clk),
        .ctl  (mul_ctl),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign take         = sample_valid && !sample_stall;
    assign load         = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);

    assign remote_shl = remote_receive_time << REM_SHIFT;
    assign remote_ext = RTIME_W'($signed(remote_shl) >>> REM_SHIFT);

    assign rtt_wide  = {1'b0, recv_reg} - {1'b0, send_reg};
    assign inst_wide = {remote_reg[RTIME_W-1], remote_reg} - {2'b00, sub_reg};
    assign diff_ab   = {inst_reg[RTIME_W-1], inst_reg} - {offset_reg[RTIME_W-1], offset_reg};
    assign diff_ba   = {offset_reg[RTIME_W-1], offset_reg} - {inst_reg[RTIME_W-1], inst_reg};
    assign dt_wide   = {1'b0, recv_reg} - {1'b0, prev_time_reg};

    assign ofs_p   = prod[PROD_W-1:16];
    assign ofs_sum = neg_reg
                   ? {{6{offset_reg[RTIME_W-1]}}, offset_reg} - {2'b00, ofs_p}
                   : {{6{offset_reg[RTIME_W-1]}}, offset_reg} + {2'b00, ofs_p};

    assign num_full  = {prod, {DRIFT_FRAC_BITS{1'b0}}};
    assign top_ext   = LTIME_W'(num_full[NUM_W-1:QUOT_W]);
    assign rem_shift = {rem_reg, num_reg[QUOT_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dt_reg};

    assign old_w     = $signed({1'b0, 17'h10000}) - $signed({1'b0, cfg.drift_gain});
    assign old_w_neg = old_w[GAIN_W];
    assign old_w_mag = old_w_neg ? GAIN_W'(-old_w) : GAIN_W'(old_w);
    assign drift_mag = drift_reg[DRIFT_W-1] ? (~drift_reg + 1'b1) : drift_reg;
    assign told_s    = (drift_reg[DRIFT_W-1] ^ old_w_neg)
                     ? SUM_W'(0) - SUM_W'(prod[47:16])
                     : SUM_W'(prod[47:16]);
    assign drift_sum = neg_reg ? told_s - SUM_W'(tnew_reg) : told_s + SUM_W'(tnew_reg);

    always_comb
    begin
        mul_ctl.en = 1'b0;
        mul_ctl.hi = 1'b0;
        mul_a      = mag_reg;
        mul_b      = MUL_B_W'(gain_reg);
        case (state_reg)
            S_OMH, S_OML:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.hi = (state_reg == S_OMH);
            end
            S_DMH, S_DML:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.hi = (state_reg == S_DMH);
                mul_b      = MEGA;
            end
            S_TMH, S_TML:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.hi = (state_reg == S_TMH);
                mul_a      = MUL_A_W'(q_reg);
                mul_b      = MUL_B_W'(cfg.drift_gain);
            end
            S_OLH, S_OLL:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.hi = (state_reg == S_OLH);
                mul_a      = MUL_A_W'(drift_mag);
                mul_b      = MUL_B_W'(old_w_mag);
            end
            default:
            begin
                mul_ctl.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        send_next      = send_reg;
        recv_next      = recv_reg;
        remote_next    = remote_reg;
        rtt_next       = rtt_reg;
        sub_next       = sub_reg;
        inst_next      = inst_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        gain_next      = gain_reg;
        dt_next        = dt_reg;
        dt_pos_next    = dt_pos_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        tnew_next      = tnew_reg;
        acc_flag_next  = acc_flag_reg;
        upd_flag_next  = upd_flag_reg;
        valid_next     = valid_reg;
        offset_next    = offset_reg;
        min_rtt_next   = min_rtt_reg;
        last_rtt_next  = last_rtt_reg;
        prev_time_next = prev_time_reg;
        drift_next     = drift_reg;
        count_next     = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    send_next     = local_send_time & LOCAL_MASK;
                    recv_next     = local_receive_time & LOCAL_MASK;
                    remote_next   = remote_ext;
                    acc_flag_next = 1'b0;
                    upd_flag_next = 1'b0;
                    state_next    = S_RTT;
                end
            end
            S_RTT:
            begin
                rtt_next = rtt_wide[LTIME_W-1:0];
                if (rtt_wide[RTIME_W-1])
                    state_next = S_DONE;
                else
                    state_next = S_MID;
            end
            S_MID:
            begin
                sub_next   = send_reg + (rtt_reg >> 1);
                state_next = S_INST;
            end
            S_INST:
            begin
                if (inst_wide[RTIME_W] && !inst_wide[RTIME_W-1])
                    inst_next = OFS_MIN;
                else
                    inst_next = inst_wide[RTIME_W-1:0];
                last_rtt_next = rtt_reg;
                if (!valid_reg)
                begin
                    offset_next  = inst_next;
                    min_rtt_next = rtt_reg;
                    valid_next   = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                neg_next    = diff_ab[RTIME_W];
                mag_next    = diff_ab[RTIME_W] ? diff_ba[RTIME_W-1:0] : diff_ab[RTIME_W-1:0];
                gain_next   = (rtt_reg <= min_rtt_reg) ? cfg.good_gain : cfg.normal_gain;
                if (rtt_reg < min_rtt_reg)
                    min_rtt_next = rtt_reg;
                dt_next     = dt_wide[LTIME_W-1:0];
                dt_pos_next = !dt_wide[RTIME_W-1] && (dt_wide != '0);
                state_next  = S_OMH;
            end
            S_OMH:
            begin
                state_next = S_OML;
            end
            S_OML:
            begin
                state_next = S_OFS;
            end
            S_OFS:
            begin
                if (!ofs_sum[OFS_W-1] && (ofs_sum[OFS_W-2:RTIME_W-1] != '0))
                    offset_next = OFS_MAX;
                else if (ofs_sum[OFS_W-1] && (ofs_sum[OFS_W-2:RTIME_W-1] != '1))
                    offset_next = OFS_MIN;
                else
                    offset_next = ofs_sum[RTIME_W-1:0];
                if ((prev_time_reg != '0) && dt_pos_reg && (dt_reg > cfg.interval))
                    state_next = S_DMH;
                else
                    state_next = S_FIN;
            end
            S_DMH:
            begin
                state_next = S_DML;
            end
            S_DML:
            begin
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                num_next = num_full[QUOT_W-1:0];
                cnt_next = CNT_W'(QUOT_W - 1);
                rem_next = top_ext;
                if (top_ext >= dt_reg)
                begin
                    q_next     = SAMPLE_CLAMP;
                    state_next = S_SCLP;
                end
                else
                begin
                    q_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_ge ? LTIME_W'(rem_shift - {1'b0, dt_reg})
                                  : rem_shift[LTIME_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], rem_ge};
                num_next = num_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_SCLP;
            end
            S_SCLP:
            begin
                if (q_reg > SAMPLE_CLAMP)
                    q_next = SAMPLE_CLAMP;
                state_next = S_TMH;
            end
            S_TMH:
            begin
                state_next = S_TML;
            end
            S_TML:
            begin
                state_next = S_TNEW;
            end
            S_TNEW:
            begin
                tnew_next  = prod[TNEW_W+15:16];
                state_next = S_OLH;
            end
            S_OLH:
            begin
                state_next = S_OLL;
            end
            S_OLL:
            begin
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                if (!drift_sum[SUM_W-1] && (drift_sum[SUM_W-2:DRIFT_W-1] != '0))
                    drift_next = DRIFT_MAX;
                else if (drift_sum[SUM_W-1] && (drift_sum[SUM_W-2:DRIFT_W-1] != '1))
                    drift_next = DRIFT_MIN;
                else
                    drift_next = drift_sum[DRIFT_W-1:0];
                upd_flag_next = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                prev_time_next = recv_reg;
                if (count_reg != '1)
                    count_next = count_reg + 1'b1;
                acc_flag_next  = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_flag_reg  <= 1'b0;
            upd_flag_reg  <= 1'b0;
            valid_reg     <= 1'b0;
            offset_reg    <= '0;
            min_rtt_reg   <= '0;
            last_rtt_reg  <= '0;
            prev_time_reg <= '0;
            drift_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_flag_reg  <= acc_flag_next;
            upd_flag_reg  <= upd_flag_next;
            valid_reg     <= valid_next;
            offset_reg    <= offset_next;
            min_rtt_reg   <= min_rtt_next;
            last_rtt_reg  <= last_rtt_next;
            prev_time_reg <= prev_time_next;
            drift_reg     <= drift_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        send_reg   <= send_next;
        recv_reg   <= recv_next;
        remote_reg <= remote_next;
        rtt_reg    <= rtt_next;
        sub_reg    <= sub_next;
        inst_reg   <= inst_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        gain_reg   <= gain_next;
        dt_reg     <= dt_next;
        dt_pos_reg <= dt_pos_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        tnew_reg   <= tnew_next;
        if (load)
        begin
            out_acc_reg    <= acc_flag_reg;
            out_offset_reg <= offset_reg;
            out_min_reg    <= min_rtt_reg;
            out_last_reg   <= last_rtt_reg;
            out_drift_reg  <= drift_reg;
            out_upd_reg    <= upd_flag_reg;
            out_have_reg   <= valid_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign accepted        = out_acc_reg;
    assign offset_estimate = $signed(out_offset_reg);
    assign min_round_trip  = out_min_reg;
    assign last_round_trip = out_last_reg;
    assign drift_ppm       = $signed(out_drift_reg);
    assign drift_updated   = out_upd_reg;
    assign have_estimate   = out_have_reg;
    assign samples_taken   = out_count_reg;

    ast_result_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_DONE)
    ) else $error("result raised without a finished request");

    ast_estimate_sticky: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$fell(valid_reg)
    ) else $error("estimate valid dropped");

    ast_update_needs_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && drift_updated) |-> (accepted && have_estimate)
    ) else $error("drift update on a rejected request");

    ast_take_starts_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == S_RTT)
    ) else $error("accepted request did not start");

endmodule

`default_nettype wire

@@ rtl/core/cod_regs.sv @@
// ----------------------------------------------------------------------------
// cod_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module cod_regs
    import cod_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cod_cfg_t               cfg
);

    cod_cfg_t   cfg_reg;
    cod_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:3];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_GOOD_GAIN:   cfg_next.good_gain   = pwdata[GAIN_W-1:0];
                REG_NORMAL_GAIN: cfg_next.normal_gain = pwdata[GAIN_W-1:0];
                REG_DRIFT_GAIN:  cfg_next.drift_gain  = pwdata[GAIN_W-1:0];
                REG_INTERVAL:    cfg_next.interval    = pwdata[LTIME_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_GOOD_GAIN:   prdata = DATA_W'(cfg_reg.good_gain);
            REG_NORMAL_GAIN: prdata = DATA_W'(cfg_reg.normal_gain);
            REG_DRIFT_GAIN:  prdata = DATA_W'(cfg_reg.drift_gain);
            REG_INTERVAL:    prdata = DATA_W'(cfg_reg.interval);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.good_gain   <= GOOD_GAIN_RST;
            cfg_reg.normal_gain <= NORMAL_GAIN_RST;
            cfg_reg.drift_gain  <= DRIFT_GAIN_RST;
            cfg_reg.interval    <= INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cod_mul.sv @@
// ----------------------------------------------------------------------------
// cod_mul
// Shared 64 x 20 multiplier built from one 32 x 20 partial product per cycle while enabled.
// High half first, then the low half is added to the shifted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cod_mul
    import cod_pkg::*;
(
    input  wire logic               clk,
    input  wire cod_mul_ctl_t       ctl,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic      [PROD_W-1:0]  prod
);

    localparam int PP_W = MUL_H_W + MUL_B_W;

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [MUL_H_W-1:0] half;
    logic [PP_W-1:0]    pp;

    assign half = ctl.hi ? a[MUL_A_W-1:MUL_H_W] : a[MUL_H_W-1:0];
    assign pp   = half * b;
    assign prod = prod_reg;

    always_comb
    begin
        if (ctl.hi)
            prod_next = PROD_W'(pp);
        else
            prod_next = {prod_reg[PROD_W-MUL_H_W-1:0], {MUL_H_W{1'b0}}} + PROD_W'(pp);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            prod_reg <= prod_next;
    end

endmodule

`default_nettype wire
